/* design/assert_macros.svh */
// Assertion macros used by the training unit back part.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/sgdr_pkg.sv */
// Types, constants and arithmetic helpers of the training unit register block.
`timescale 1ns / 1ps
`default_nettype none
package sgdr_pkg;
	localparam logic [6:0] CMD_ADDR  = 7'd28;
	localparam logic [6:0] W1_BASE   = 7'd32;
	localparam logic [6:0] W2_BASE   = 7'd48;
	localparam logic [6:0] D2_BASE   = 7'd64;
	localparam logic [6:0] D1_BASE   = 7'd68;
	localparam logic [6:0] LOSS_ADDR = 7'd76;
	localparam logic [6:0] GRAD_BASE = 7'd12;

	localparam int CMD_BITS = 5;
	localparam int CMD_OUT  = 0;
	localparam int CMD_HID  = 1;
	localparam int CMD_W2   = 2;
	localparam int CMD_W1   = 3;
	localparam int CMD_CLR  = 4;

	typedef enum logic [3:0] {
		TGT_NONE, TGT_ACT, TGT_PRE, TGT_TGT, TGT_GRAD, TGT_CMD,
		TGT_W1, TGT_W2, TGT_OD, TGT_HD, TGT_LOSS
	} tgt_t;

	typedef struct packed {
		logic        wr;
		tgt_t        tgt;
		logic [3:0]  idx;
		logic [31:0] data;
	} op_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ERR  = 7'b0000010,
		ST_OUT  = 7'b0000100,
		ST_HID  = 7'b0001000,
		ST_W2   = 7'b0010000,
		ST_W1   = 7'b0100000,
		ST_CLR  = 7'b1000000
	} st_t;

	function automatic logic signed [31:0] clamp_f(input logic signed [31:0] v,
		input logic [30:0] lim);
		logic signed [32:0] l;
		logic signed [32:0] w;
		logic signed [31:0] r;
		l = (lim == 31'd0) ? 33'sd1 : $signed({2'b00, lim});
		w = 33'(v);
		if (w < -l) r = 32'(-l);
		else if (w > l - 33'sd1) r = 32'(l - 33'sd1);
		else r = v;
		return r;
	endfunction

	function automatic logic signed [31:0] leaky_f(input logic signed [31:0] x,
		input logic neg, input logic [3:0] ls, input logic [4:0] frac);
		logic signed [63:0] p;
		logic [4:0] sh;
		logic signed [31:0] r;
		sh = neg ? (frac - 5'(ls)) : frac;
		p = (64'(x) <<< sh) + (64'sd1 <<< (frac - 5'd1));
		p = p >>> frac;
		if (neg && (5'(ls) > frac)) r = 32'sd0;
		else r = p[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] upd_f(input logic signed [31:0] w,
		input logic signed [31:0] g, input logic [4:0] rs);
		logic signed [33:0] d;
		logic signed [31:0] r;
		d = 34'(w) - 34'(g >>> rs);
		if (d < -34'sd32768) r = -32'sd32768;
		else if (d > 34'sd32767) r = 32'sd32767;
		else r = d[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

/* design/sgdr_front.sv */
// Front part: accepts bus requests and decodes each into a bank target.
`timescale 1ns / 1ps
`default_nettype none
module sgdr_front (
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic                req_type,
	input  wire logic [6:0]          word_addr,
	input  wire logic signed [31:0]  write_data,
	output logic                     push,
	output sgdr_pkg::op_t            push_op,
	input  wire logic                q_full
);
	import sgdr_pkg::*;

	assign req_ready = !q_full;
	assign push = req_valid && !q_full;

	always_comb begin
		push_op.wr = req_type;
		push_op.data = write_data;
		push_op.idx = 4'(word_addr[1:0]);
		push_op.tgt = TGT_NONE;
		if (req_type) begin
			if (word_addr <= 7'd3) push_op.tgt = TGT_ACT;
			else if (word_addr <= 7'd7) push_op.tgt = TGT_PRE;
			else if (word_addr <= 7'd11) push_op.tgt = TGT_TGT;
			else if (word_addr <= 7'd27) begin
				push_op.tgt = TGT_GRAD;
				push_op.idx = 4'(word_addr - GRAD_BASE);
			end else if (word_addr == CMD_ADDR) push_op.tgt = TGT_CMD;
		end else begin
			if (word_addr == LOSS_ADDR) push_op.tgt = TGT_LOSS;
			else if (word_addr >= D1_BASE && word_addr <= 7'd71) push_op.tgt = TGT_HD;
			else if (word_addr >= D2_BASE && word_addr <= 7'd65) push_op.tgt = TGT_OD;
		end
		if (word_addr >= W1_BASE && word_addr <= 7'd47) begin
			push_op.tgt = TGT_W1;
			push_op.idx = word_addr[3:0];
		end else if (word_addr >= W2_BASE && word_addr <= 7'd55) begin
			push_op.tgt = TGT_W2;
			push_op.idx = 4'(word_addr[2:0]);
		end
	end
endmodule
`default_nettype wire

/* design/sgdr_queue.sv */
// Two-entry queue of decoded requests between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module sgdr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sgdr_pkg::op_t  push_op,
	output logic                full,
	input  wire logic           pop,
	output logic                head_valid,
	output sgdr_pkg::op_t       head
);
	import sgdr_pkg::*;

	op_t        mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_op;
	end
endmodule
`default_nettype wire

/* design/sgdr_back.sv */
// Back part: holds the banks, answers accesses and sequences the training commands.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sgdr_back #(
	parameter int NUM_OUT = 2,
	parameter int NUM_HIDDEN = 4,
	parameter int NUM_IN = 4,
	parameter int FRAC_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [30:0]         cfg_data,
	input  wire logic                head_valid,
	input  wire sgdr_pkg::op_t       head,
	output logic                     pop,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic signed [31:0]       read_data
);
	import sgdr_pkg::*;

	localparam int OUT_N = (NUM_OUT < 4) ? NUM_OUT : 4;
	localparam int HID_N = (NUM_HIDDEN < 4) ? NUM_HIDDEN : 4;
	localparam int W2_N = (NUM_OUT * NUM_HIDDEN < 8) ? NUM_OUT * NUM_HIDDEN : 8;
	localparam int W1_N = (NUM_HIDDEN * NUM_IN < 16) ? NUM_HIDDEN * NUM_IN : 16;
	localparam logic [4:0] FRAC = 5'(FRAC_BITS);

	logic signed [31:0] act_q [4];
	logic signed [31:0] pre_q [4];
	logic signed [31:0] tgt_q [4];
	logic signed [31:0] grad_q [16];
	logic signed [31:0] w1_q [16];
	logic signed [31:0] w2_q [8];
	logic signed [31:0] od_q [2];
	logic signed [31:0] hd_q [4];
	logic [31:0]        loss_q;
	logic [3:0]         leaky_q;
	logic [4:0]         rate_q;
	logic [30:0]        elim_q;
	logic [30:0]        dlim_q;
	st_t                st_q;
	logic [CMD_BITS-1:0] cmd_q;
	logic [3:0]         idx_q;
	logic signed [31:0] e_q;
	logic               out_valid_q;
	logic signed [31:0] rdata_q;

	logic signed [31:0] rd_val;
	logic signed [32:0] diff;
	logic signed [31:0] e_clamped;
	logic signed [63:0] sq;
	logic signed [31:0] od_new;
	logic signed [31:0] hd_new;

	function automatic st_t next_st(input logic [CMD_BITS-1:0] cmd, input int from);
		st_t r;
		r = ST_IDLE;
		for (int k = CMD_BITS - 1; k >= 0; k--) begin
			if (k >= from && cmd[k]) begin
				case (k)
					CMD_OUT: r = ST_ERR;
					CMD_HID: r = ST_HID;
					CMD_W2: r = ST_W2;
					CMD_W1: r = ST_W1;
					default: r = ST_CLR;
				endcase
			end
		end
		return r;
	endfunction

	assign pop = head_valid && (st_q == ST_IDLE) && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign read_data = rdata_q;

	always_comb begin
		rd_val = 32'sd0;
		case (head.tgt)
			TGT_W1: rd_val = w1_q[head.idx];
			TGT_W2: rd_val = w2_q[head.idx[2:0]];
			TGT_OD: rd_val = od_q[head.idx[0]];
			TGT_HD: rd_val = hd_q[head.idx[1:0]];
			TGT_LOSS: rd_val = loss_q;
			default: rd_val = 32'sd0;
		endcase
	end

	always_comb begin
		diff = 33'(act_q[idx_q[1:0]]) - 33'(tgt_q[idx_q[1:0]]);
		if (diff > 33'sd2147483647) e_clamped = 32'sd2147483647;
		else if (diff < -33'sd2147483648) e_clamped = -32'sd2147483648;
		else e_clamped = diff[31:0];
		e_clamped = clamp_f(e_clamped, elim_q);
		sq = (64'(e_q) * 64'(e_q) + (64'sd1 <<< (FRAC - 5'd1))) >>> FRAC;
		od_new = clamp_f(leaky_f(e_q, pre_q[idx_q[1:0]][31], leaky_q, FRAC), dlim_q);
		hd_new = clamp_f(leaky_f(act_q[idx_q[1:0]], pre_q[idx_q[1:0]][31], leaky_q, FRAC),
			dlim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaky_q <= 4'd3;
			rate_q <= 5'd4;
			elim_q <= 31'd32768;
			dlim_q <= 31'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				2'd0: leaky_q <= cfg_data[3:0];
				2'd1: rate_q <= cfg_data[4:0];
				2'd2: elim_q <= cfg_data;
				default: dlim_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				act_q[i] <= '0;
				pre_q[i] <= '0;
				tgt_q[i] <= '0;
				hd_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) begin
				grad_q[i] <= '0;
				w1_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) w2_q[i] <= '0;
			od_q[0] <= '0;
			od_q[1] <= '0;
			loss_q <= '0;
			st_q <= ST_IDLE;
			cmd_q <= '0;
			idx_q <= '0;
			e_q <= '0;
			out_valid_q <= 1'b0;
			rdata_q <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				rdata_q <= head.wr ? 32'sd0 : rd_val;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (pop && head.wr) begin
						case (head.tgt)
							TGT_ACT: act_q[head.idx[1:0]] <= head.data;
							TGT_PRE: pre_q[head.idx[1:0]] <= head.data;
							TGT_TGT: tgt_q[head.idx[1:0]] <= head.data;
							TGT_GRAD: grad_q[head.idx] <= head.data;
							TGT_W1: w1_q[head.idx] <= head.data;
							TGT_W2: w2_q[head.idx[2:0]] <= head.data;
							TGT_CMD: begin
								cmd_q <= head.data[CMD_BITS-1:0];
								st_q <= next_st(head.data[CMD_BITS-1:0], CMD_OUT);
							end
							default: ;
						endcase
					end
				end
				ST_ERR: begin
					e_q <= e_clamped;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					loss_q <= loss_q + sq[31:0];
					if (idx_q < 4'd2) od_q[idx_q[0]] <= od_new;
					if (idx_q == 4'(OUT_N - 1)) begin
						idx_q <= '0;
						st_q <= next_st(cmd_q, CMD_HID);
					end else begin
						idx_q <= idx_q + 4'd1;
						st_q <= ST_ERR;
					end
				end
				ST_HID: begin
					hd_q[idx_q[1:0]] <= hd_new;
					if (idx_q == 4'(HID_N - 1)) begin
						idx_q <= '0;
						st_q <= next_st(cmd_q, CMD_W2);
					end else idx_q <= idx_q + 4'd1;
				end
				ST_W2: begin
					w2_q[idx_q[2:0]] <= upd_f(w2_q[idx_q[2:0]], grad_q[idx_q], rate_q);
					if (idx_q == 4'(W2_N - 1)) begin
						idx_q <= '0;
						st_q <= next_st(cmd_q, CMD_W1);
					end else idx_q <= idx_q + 4'd1;
				end
				ST_W1: begin
					w1_q[idx_q] <= upd_f(w1_q[idx_q], grad_q[idx_q], rate_q);
					if (idx_q == 4'(W1_N - 1)) begin
						idx_q <= '0;
						st_q <= next_st(cmd_q, CMD_CLR);
					end else idx_q <= idx_q + 4'd1;
				end
				ST_CLR: begin
					loss_q <= '0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_busy_no_pop, clk, arst_n, st_q != ST_IDLE, !pop)
	`ASSERT_NXT(a_cmd_starts, clk, arst_n, pop && head.wr && (head.tgt == TGT_CMD) && (head.data[4:0] != 5'd0), st_q != ST_IDLE)
	`ASSERT_IMP(a_w1_range, clk, arst_n, st_q == ST_W1, idx_q <= 4'(W1_N - 1))
endmodule
`default_nettype wire

/* design/sgd_train_unit_registers.sv */
// Responses: a request waits in the queue, is popped while the back part is idle, and its response is registered.
// Throughput: one access per cycle while the back part is idle and responses are taken; a command
// word holds the back part while its sequencer steps through the selected output deltas, hidden
// deltas, W2 and W1 updates and the loss clear, while the queue still takes two requests.
// Reset: arst_n clears all banks, deltas, loss and the queue and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module sgd_train_unit_registers #(
	parameter int NUM_OUT = 2,
	parameter int NUM_HIDDEN = 4,
	parameter int NUM_IN = 4,
	parameter int FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic               req_type,
	input  wire logic [6:0]         word_addr,
	input  wire logic signed [31:0] write_data,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic signed [31:0]      read_data
);
	import sgdr_pkg::*;

	logic push;
	op_t  push_op;
	logic q_full;
	logic pop;
	logic head_valid;
	op_t  head;

	sgdr_front u_front (
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.word_addr(word_addr), .write_data(write_data), .push(push),
		.push_op(push_op), .q_full(q_full)
	);

	sgdr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_op(push_op), .full(q_full),
		.pop(pop), .head_valid(head_valid), .head(head)
	);

	sgdr_back #(
		.NUM_OUT(NUM_OUT), .NUM_HIDDEN(NUM_HIDDEN), .NUM_IN(NUM_IN), .FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .head_valid(head_valid), .head(head), .pop(pop),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .read_data(read_data)
	);
endmodule
`default_nettype wire
